// File: rtl/core/sa_pkg.sv
// Shared constants, types and helper functions for the shortest-arc quaternion block.
package sa_pkg;

  localparam int FRAC_BITS  = 14;
  localparam int IN_WIDTH   = 16;
  localparam int FB_WIDTH   = 16;
  localparam int OUT_WIDTH  = 16;
  localparam int NRM_FRAC   = 30;
  localparam int LANES      = 4;
  localparam int MAG_W      = 62;
  localparam int NM_W       = 30;
  localparam int POS_W      = 6;
  localparam int SQ_W       = 2 * NM_W;
  localparam int ROOT_W     = MAG_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int QUO_W      = 31;
  localparam int NUM_W      = NM_W + NRM_FRAC + 1;
  localparam int DREM_W     = ROOT_W + 1;
  localparam int UQ_W       = QUO_W + 1;
  localparam int FRAC_SEL_W = 5;
  localparam int PROD_W     = 64;

  localparam logic signed [PROD_W-1:0] ONE_Q60   = 64'sd1152921504606846976;
  localparam logic signed [PROD_W-1:0] EPS_THR   = 64'sd1152921504607 - ONE_Q60;
  localparam logic [PROD_W-1:0]        NEAR_ZERO = 64'd16384;

  localparam logic signed [UQ_W-1:0] OUT_HI = UQ_W'((64'sd1 <<< (OUT_WIDTH - 1)) - 64'sd1);
  localparam logic signed [UQ_W-1:0] OUT_LO = -OUT_HI - UQ_W'(1);

  typedef enum logic [1:0] {
    PATH_SAME      = 2'd0,
    PATH_FALLBACK  = 2'd1,
    PATH_GENERATED = 2'd2,
    PATH_GENERAL   = 2'd3
  } path_e;

  typedef struct packed {
    logic signed [FB_WIDTH-1:0] fb_x;
    logic signed [FB_WIDTH-1:0] fb_y;
    logic signed [FB_WIDTH-1:0] fb_z;
    path_e                      path;
  } side_t;

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] a;
    a = v[PROD_W-1] ? -v : v;
    return a[MAG_W-1:0];
  endfunction

  function automatic logic [OUT_WIDTH-1:0] sat_out(input logic signed [UQ_W-1:0] v);
    logic signed [UQ_W-1:0] c;
    c = v;
    if (v > OUT_HI) begin
      c = OUT_HI;
    end else if (v < OUT_LO) begin
      c = OUT_LO;
    end
    return c[OUT_WIDTH-1:0];
  endfunction

endpackage

// File: rtl/core/sa_unit.sv
// Pipelined vector unitizer: block scaling, sum of squares, square root and rounded division.
module sa_unit (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        en_i,
  input  logic                                        valid_i,
  input  logic [sa_pkg::FRAC_SEL_W-1:0]               frac_i,
  input  logic [sa_pkg::LANES-1:0][sa_pkg::MAG_W-1:0] mag_i,
  input  logic [sa_pkg::LANES-1:0]                    neg_i,
  input  sa_pkg::side_t                               side_i,
  output logic                                        valid_o,
  output logic [sa_pkg::LANES-1:0][sa_pkg::UQ_W-1:0]  q_o,
  output sa_pkg::side_t                               side_o
);
  import sa_pkg::*;

  logic                             v0_q, v1_q, v2_q, v3_q;
  logic [LANES-1:0][MAG_W-1:0]      mag0_q, mag1_q;
  logic [LANES-1:0]                 neg0_q, neg1_q, neg2_q, neg3_q;
  side_t                            side0_q, side1_q, side2_q, side3_q;
  logic                             right1_q, zero1_q, zero2_q, zero3_q;
  logic [POS_W-1:0]                 amt1_q;
  logic [LANES-1:0][NM_W-1:0]       m2_q, m3_q;
  logic [LANES-1:0][SQ_W-1:0]       sq3_q;

  logic [MAG_W-1:0]                 all_or;
  logic [POS_W-1:0]                 msb;
  logic                             right_d;
  logic [POS_W-1:0]                 amt_d;
  logic [LANES-1:0][MAG_W-1:0]      shr_c, shl_c;
  logic [LANES-1:0][NM_W-1:0]       m2_d;
  logic [LANES-1:0][SQ_W-1:0]       sq_d;
  logic [MAG_W-1:0]                 sum_d;

  logic                             sv_q    [ROOT_W+1];
  logic [MAG_W-1:0]                 srad_q  [ROOT_W+1];
  logic [REM_W-1:0]                 srem_q  [ROOT_W+1];
  logic [ROOT_W-1:0]                sroot_q [ROOT_W+1];
  logic [LANES-1:0][NM_W-1:0]       sm_q    [ROOT_W+1];
  logic [LANES-1:0]                 sneg_q  [ROOT_W+1];
  logic                             szero_q [ROOT_W+1];
  side_t                            sside_q [ROOT_W+1];

  logic                             dv_q    [QUO_W+1];
  logic [LANES-1:0][NUM_W-1:0]      dnum_q  [QUO_W+1];
  logic [LANES-1:0][DREM_W-1:0]     drem_q  [QUO_W+1];
  logic [LANES-1:0][QUO_W-1:0]      dquo_q  [QUO_W+1];
  logic [ROOT_W-1:0]                dr_q    [QUO_W+1];
  logic [LANES-1:0]                 dneg_q  [QUO_W+1];
  logic                             dzero_q [QUO_W+1];
  side_t                            dside_q [QUO_W+1];

  logic [LANES-1:0][NUM_W-1:0]      num_d;
  logic [LANES-1:0][DREM_W-1:0]     rem0_d;
  logic [LANES-1:0][UQ_W-1:0]       q_d;
  logic                             out_v_q;
  logic [LANES-1:0][UQ_W-1:0]       q_q;
  side_t                            side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_comb begin
    all_or = '0;
    for (int l = 0; l < LANES; l++) begin
      all_or = all_or | mag0_q[l];
    end
    msb = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (all_or[b]) begin
        msb = POS_W'(b);
      end
    end
    right_d = msb > POS_W'(NM_W - 1);
    amt_d   = right_d ? msb - POS_W'(NM_W - 1) : POS_W'(NM_W - 1) - msb;
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      shr_c[l] = mag1_q[l] >> amt1_q;
      shl_c[l] = mag1_q[l] << amt1_q;
      m2_d[l]  = right1_q ? shr_c[l][NM_W-1:0] : shl_c[l][NM_W-1:0];
      sq_d[l]  = SQ_W'(m2_q[l]) * SQ_W'(m2_q[l]);
    end
    sum_d = '0;
    for (int l = 0; l < LANES; l++) begin
      sum_d = sum_d + MAG_W'(sq3_q[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag0_q   <= mag_i;
      neg0_q   <= neg_i;
      side0_q  <= side_i;
      mag1_q   <= mag0_q;
      neg1_q   <= neg0_q;
      side1_q  <= side0_q;
      right1_q <= right_d;
      amt1_q   <= amt_d;
      zero1_q  <= (all_or == '0);
      m2_q     <= m2_d;
      neg2_q   <= neg1_q;
      side2_q  <= side1_q;
      zero2_q  <= zero1_q;
      sq3_q    <= sq_d;
      m3_q     <= m2_q;
      neg3_q   <= neg2_q;
      side3_q  <= side2_q;
      zero3_q  <= zero2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else if (en_i) begin
      sv_q[0] <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      srad_q[0]  <= sum_d;
      srem_q[0]  <= '0;
      sroot_q[0] <= '0;
      sm_q[0]    <= m3_q;
      sneg_q[0]  <= neg3_q;
      szero_q[0] <= zero3_q;
      sside_q[0] <= side3_q;
    end
  end

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    localparam int K = ROOT_W - 1 - j;
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    logic             take;

    assign cur   = {srem_q[j], srad_q[j][2*K+1 -: 2]};
    assign trial = (REM_W + 2)'({sroot_q[j], 2'b01});
    assign take  = cur >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[j+1] <= 1'b0;
      end else if (en_i) begin
        sv_q[j+1] <= sv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        srem_q[j+1]  <= take ? REM_W'(cur - trial) : REM_W'(cur);
        sroot_q[j+1] <= {sroot_q[j][ROOT_W-2:0], take};
        srad_q[j+1]  <= srad_q[j];
        sm_q[j+1]    <= sm_q[j];
        sneg_q[j+1]  <= sneg_q[j];
        szero_q[j+1] <= szero_q[j];
        sside_q[j+1] <= sside_q[j];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      num_d[l]  = (NUM_W'(sm_q[ROOT_W][l]) << frac_i) + NUM_W'(sroot_q[ROOT_W] >> 1);
      rem0_d[l] = DREM_W'(num_d[l] >> QUO_W);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_q[0] <= sv_q[ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dnum_q[0]  <= num_d;
      drem_q[0]  <= rem0_d;
      dquo_q[0]  <= '0;
      dr_q[0]    <= sroot_q[ROOT_W];
      dneg_q[0]  <= sneg_q[ROOT_W];
      dzero_q[0] <= szero_q[ROOT_W];
      dside_q[0] <= sside_q[ROOT_W];
    end
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    localparam int K = QUO_W - 1 - j;
    logic [LANES-1:0][DREM_W-1:0] cur;
    logic [LANES-1:0][DREM_W-1:0] rem_d;
    logic [LANES-1:0][QUO_W-1:0]  quo_d;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        cur[l] = {drem_q[j][l][DREM_W-2:0], dnum_q[j][l][K]};
        if (cur[l] >= DREM_W'(dr_q[j])) begin
          rem_d[l] = cur[l] - DREM_W'(dr_q[j]);
          quo_d[l] = {dquo_q[j][l][QUO_W-2:0], 1'b1};
        end else begin
          rem_d[l] = cur[l];
          quo_d[l] = {dquo_q[j][l][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[j+1] <= 1'b0;
      end else if (en_i) begin
        dv_q[j+1] <= dv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        drem_q[j+1]  <= rem_d;
        dquo_q[j+1]  <= quo_d;
        dnum_q[j+1]  <= dnum_q[j];
        dr_q[j+1]    <= dr_q[j];
        dneg_q[j+1]  <= dneg_q[j];
        dzero_q[j+1] <= dzero_q[j];
        dside_q[j+1] <= dside_q[j];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (dzero_q[QUO_W]) begin
        q_d[l] = '0;
      end else if (dneg_q[QUO_W][l]) begin
        q_d[l] = -UQ_W'(dquo_q[QUO_W][l]);
      end else begin
        q_d[l] = UQ_W'(dquo_q[QUO_W][l]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en_i) begin
      out_v_q <= dv_q[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q    <= q_d;
      side_q <= dside_q[QUO_W];
    end
  end

  assign valid_o = out_v_q;
  assign q_o     = q_q;
  assign side_o  = side_q;

endmodule

// File: rtl/core/sa_arc.sv
// Dot and cross products of the unit vectors and selection of the final axis case.
module sa_arc (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         en_i,
  input  logic                                         valid_i,
  input  logic [sa_pkg::LANES-1:0][sa_pkg::UQ_W-1:0]   u0_i,
  input  logic [sa_pkg::LANES-1:0][sa_pkg::UQ_W-1:0]   u1_i,
  input  sa_pkg::side_t                                side_i,
  output logic                                         valid_o,
  output logic [sa_pkg::LANES-1:0][sa_pkg::PROD_W-1:0] t_o,
  output sa_pkg::side_t                                side_o
);
  import sa_pkg::*;

  logic signed [UQ_W-1:0]   ax, ay, az, bx, by, bz;
  logic                     v1_q, v2_q, v3_q;
  logic signed [PROD_W-1:0] pdx_q, pdy_q, pdz_q;
  logic signed [PROD_W-1:0] p_yz_q, p_zy_q, p_zx_q, p_xz_q, p_xy_q, p_yx_q;
  logic signed [PROD_W-1:0] p_zz_q, p_yy_q;
  logic signed [UQ_W-1:0]   ux1_q, uy1_q, uz1_q, ux2_q, uy2_q, uz2_q;
  side_t                    side1_q, side2_q, side3_q;
  logic signed [PROD_W-1:0] d2_q, cx2_q, cy2_q, cz2_q;
  logic [PROD_W-1:0]        n2_q;
  logic [LANES-1:0][PROD_W-1:0] t_d, t_q;
  path_e                    path_d;
  logic                     fb_nz;

  assign ax = $signed(u0_i[0]);
  assign ay = $signed(u0_i[1]);
  assign az = $signed(u0_i[2]);
  assign bx = $signed(u1_i[0]);
  assign by = $signed(u1_i[1]);
  assign bz = $signed(u1_i[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pdx_q   <= ax * bx;
      pdy_q   <= ay * by;
      pdz_q   <= az * bz;
      p_yz_q  <= ay * bz;
      p_zy_q  <= az * by;
      p_zx_q  <= az * bx;
      p_xz_q  <= ax * bz;
      p_xy_q  <= ax * by;
      p_yx_q  <= ay * bx;
      p_zz_q  <= az * az;
      p_yy_q  <= ay * ay;
      ux1_q   <= ax;
      uy1_q   <= ay;
      uz1_q   <= az;
      side1_q <= side_i;

      d2_q    <= pdx_q + pdy_q + pdz_q;
      cx2_q   <= p_yz_q - p_zy_q;
      cy2_q   <= p_zx_q - p_xz_q;
      cz2_q   <= p_xy_q - p_yx_q;
      n2_q    <= p_zz_q + p_yy_q;
      ux2_q   <= ux1_q;
      uy2_q   <= uy1_q;
      uz2_q   <= uz1_q;
      side2_q <= side1_q;

      t_q     <= t_d;
      side3_q <= '{fb_x: '0, fb_y: '0, fb_z: '0, path: path_d};
    end
  end

  assign fb_nz = (side2_q.fb_x != '0) || (side2_q.fb_y != '0) || (side2_q.fb_z != '0);

  always_comb begin
    t_d    = '0;
    path_d = PATH_GENERAL;
    if (d2_q >= ONE_Q60) begin
      t_d[0] = PROD_W'(1);
      path_d = PATH_SAME;
    end else if (d2_q < EPS_THR) begin
      if (fb_nz) begin
        t_d[1] = PROD_W'(side2_q.fb_x);
        t_d[2] = PROD_W'(side2_q.fb_y);
        t_d[3] = PROD_W'(side2_q.fb_z);
        path_d = PATH_FALLBACK;
      end else if (n2_q < NEAR_ZERO) begin
        t_d[1] = PROD_W'(uz2_q);
        t_d[3] = -PROD_W'(ux2_q);
        path_d = PATH_GENERATED;
      end else begin
        t_d[2] = -PROD_W'(uz2_q);
        t_d[3] = PROD_W'(uy2_q);
        path_d = PATH_GENERATED;
      end
    end else begin
      t_d[0] = ONE_Q60 + d2_q;
      t_d[1] = cx2_q;
      t_d[2] = cy2_q;
      t_d[3] = cz2_q;
    end
  end

  assign valid_o = v3_q;
  assign t_o     = t_q;
  assign side_o  = side3_q;

endmodule

// File: rtl/core/shortest_arc_quaternion_top.sv
// Shortest-arc rotation quaternion between two integer 3-vectors, fully pipelined.
// Input channel: in_valid_i / in_stall_o carry the vectors from and dest (16-bit
// signed integers) and an optional fallback axis in Q1.14; a transfer happens at
// a rising edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i carry the quaternion (w, x, y, z) in
// Q1.14 and the case that produced it in path_taken_o.
// From an input transfer to the output valid, a result passes through two
// unitizers of 69 stages each, set by their one-bit-per-stage square root and
// division, plus three product and selection stages and the output register.
// Throughput is one transfer per cycle while no output stall holds the pipeline.
// A reset clears every valid bit in the pipeline, so no result is presented
// until a new input transfer has travelled through.
// While the output holds a result and the receiver stalls, the whole pipeline
// holds and in_stall_o is raised; nothing is dropped or repeated. Bubbles let
// the pipeline advance as long as the output register is empty.
module shortest_arc_quaternion_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [sa_pkg::IN_WIDTH-1:0]   from_x_i,
  input  logic signed [sa_pkg::IN_WIDTH-1:0]   from_y_i,
  input  logic signed [sa_pkg::IN_WIDTH-1:0]   from_z_i,
  input  logic signed [sa_pkg::IN_WIDTH-1:0]   dest_x_i,
  input  logic signed [sa_pkg::IN_WIDTH-1:0]   dest_y_i,
  input  logic signed [sa_pkg::IN_WIDTH-1:0]   dest_z_i,
  input  logic signed [sa_pkg::FB_WIDTH-1:0]   fallback_x_i,
  input  logic signed [sa_pkg::FB_WIDTH-1:0]   fallback_y_i,
  input  logic signed [sa_pkg::FB_WIDTH-1:0]   fallback_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [sa_pkg::OUT_WIDTH-1:0]  quat_w_o,
  output logic signed [sa_pkg::OUT_WIDTH-1:0]  quat_x_o,
  output logic signed [sa_pkg::OUT_WIDTH-1:0]  quat_y_o,
  output logic signed [sa_pkg::OUT_WIDTH-1:0]  quat_z_o,
  output logic [1:0]                           path_taken_o
);
  import sa_pkg::*;

  logic                         en;
  logic [LANES-1:0][MAG_W-1:0]  mag_a, mag_b, mag_c;
  logic [LANES-1:0]             neg_a, neg_b, neg_c;
  side_t                        side_in, side_a, side_t3, side_c;
  logic                         valid_a, valid_t3, valid_c;
  logic [LANES-1:0][UQ_W-1:0]   qa, qb, qc;
  logic [LANES-1:0][PROD_W-1:0] t3;
  logic                         out_v_q;
  logic [OUT_WIDTH-1:0]         w_q, x_q, y_q, z_q;
  path_e                        path_q;

  assign en         = !(out_v_q && out_stall_i);
  assign in_stall_o = !en;

  always_comb begin
    mag_a    = '0;
    mag_b    = '0;
    mag_a[0] = mag_of(PROD_W'(from_x_i));
    mag_a[1] = mag_of(PROD_W'(from_y_i));
    mag_a[2] = mag_of(PROD_W'(from_z_i));
    mag_b[0] = mag_of(PROD_W'(dest_x_i));
    mag_b[1] = mag_of(PROD_W'(dest_y_i));
    mag_b[2] = mag_of(PROD_W'(dest_z_i));
    neg_a    = {1'b0, from_z_i[IN_WIDTH-1], from_y_i[IN_WIDTH-1], from_x_i[IN_WIDTH-1]};
    neg_b    = {1'b0, dest_z_i[IN_WIDTH-1], dest_y_i[IN_WIDTH-1], dest_x_i[IN_WIDTH-1]};
    for (int l = 0; l < LANES; l++) begin
      mag_c[l] = mag_of($signed(t3[l]));
      neg_c[l] = t3[l][PROD_W-1];
    end
  end

  assign side_in = '{fb_x: fallback_x_i, fb_y: fallback_y_i, fb_z: fallback_z_i,
                     path: PATH_SAME};

  sa_unit u_unit_from (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .frac_i  (FRAC_SEL_W'(NRM_FRAC)),
    .mag_i   (mag_a),
    .neg_i   (neg_a),
    .side_i  (side_in),
    .valid_o (valid_a),
    .q_o     (qa),
    .side_o  (side_a)
  );

  sa_unit u_unit_dest (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .frac_i  (FRAC_SEL_W'(NRM_FRAC)),
    .mag_i   (mag_b),
    .neg_i   (neg_b),
    .side_i  ('0),
    .valid_o (),
    .q_o     (qb),
    .side_o  ()
  );

  sa_arc u_arc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_a),
    .u0_i    (qa),
    .u1_i    (qb),
    .side_i  (side_a),
    .valid_o (valid_t3),
    .t_o     (t3),
    .side_o  (side_t3)
  );

  sa_unit u_unit_quat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_t3),
    .frac_i  (FRAC_SEL_W'(FRAC_BITS)),
    .mag_i   (mag_c),
    .neg_i   (neg_c),
    .side_i  (side_t3),
    .valid_o (valid_c),
    .q_o     (qc),
    .side_o  (side_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= valid_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_q    <= sat_out($signed(qc[0]));
      x_q    <= sat_out($signed(qc[1]));
      y_q    <= sat_out($signed(qc[2]));
      z_q    <= sat_out($signed(qc[3]));
      path_q <= side_c.path;
    end
  end

  assign out_valid_o  = out_v_q;
  assign quat_w_o     = $signed(w_q);
  assign quat_x_o     = $signed(x_q);
  assign quat_y_o     = $signed(y_q);
  assign quat_z_o     = $signed(z_q);
  assign path_taken_o = path_q;

endmodule
